// File: src/udp_rx_pkg.sv
package udp_rx_pkg;

   localparam int BUS_BYTES_DEF = 8;
   localparam int CNT_W         = 4;
   localparam int BEAT_SUM_W    = 19;
   localparam int TOTAL_W       = 20;

   localparam logic [15:0] PROTO_UDP  = 16'd17;
   localparam logic [15:0] HDR_BYTES  = 16'd8;
   localparam logic [16:0] OFFSET_SAT = 17'h0ffff;
   localparam logic [15:0] CKS_GOOD   = 16'hffff;

   // header byte positions within the 8-byte header
   localparam logic [2:0] HDR_SRC_HI = 3'd0;
   localparam logic [2:0] HDR_SRC_LO = 3'd1;
   localparam logic [2:0] HDR_DST_HI = 3'd2;
   localparam logic [2:0] HDR_DST_LO = 3'd3;
   localparam logic [2:0] HDR_CKS_HI = 3'd6;
   localparam logic [2:0] HDR_CKS_LO = 3'd7;

   typedef struct packed {
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] udp_len;
      logic [63:0] beat_data;
      logic [3:0]  beat_bytes;
      logic        beat_last;
   } req_type;

   typedef struct packed {
      logic [63:0] payload_data;
      logic [3:0]  payload_bytes;
      logic        done_res;
      logic        checksum_ok;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [15:0] payload_total;
   } rsp_type;

   typedef struct packed {
      logic        kept;
      logic        payload;
      logic [2:0]  hdr_pos;
      logic [7:0]  data;
      logic [15:0] term;
   } lane_res_type;

   typedef struct packed {
      logic [63:0]           payload_data;
      logic [CNT_W-1:0]      payload_bytes;
      logic [CNT_W-1:0]      kept_cnt;
      logic [BEAT_SUM_W-1:0] beat_sum;
      logic [15:0]           src_port;
      logic [15:0]           dst_port;
      logic [15:0]           hdr_sum;
   } merge_res_type;

   // end-around carry fold of a wide integer sum into 16 bits
   function automatic logic [15:0] oc_fold(input logic [TOTAL_W-1:0] total);
      logic [16:0] part;
      logic [15:0] res;
      part = {1'b0, total[15:0]} + 17'(total[TOTAL_W-1:16]);
      res  = part[15:0] + 16'(part[16]);
      return res;
   endfunction

endpackage

// File: src/udp_rx_lane.sv
module udp_rx_lane #(
   parameter int LANE = 0
) (
   input  logic [15:0]                     byte_offset,
   input  logic [udp_rx_pkg::CNT_W-1:0]    beat_cnt,
   input  logic [7:0]                      lane_data,
   output udp_rx_pkg::lane_res_type        lane_res
);

   logic [16:0] raw_off;
   logic [15:0] off;
   logic        active;
   logic        kept;

   always_comb begin
      raw_off = {1'b0, byte_offset} + 17'(LANE);
      off     = raw_off[15:0];
      active  = beat_cnt > udp_rx_pkg::CNT_W'(LANE);
      // drop a byte that lands on or past the saturated offset
      kept    = active && (raw_off < udp_rx_pkg::OFFSET_SAT);

      lane_res.kept    = kept;
      lane_res.payload = kept && (off >= udp_rx_pkg::HDR_BYTES);
      lane_res.hdr_pos = off[2:0];
      lane_res.data    = lane_data;
      if (!kept) begin
         lane_res.term = 16'h0000;
      end else if (off[0]) begin
         lane_res.term = {8'h00, lane_data};
      end else begin
         lane_res.term = {lane_data, 8'h00};
      end
   end

endmodule

// File: src/udp_rx_merge.sv
module udp_rx_merge #(
   parameter int BUS_BYTES = udp_rx_pkg::BUS_BYTES_DEF
) (
   input  udp_rx_pkg::lane_res_type  lane_res [BUS_BYTES],
   input  logic [15:0]               src_port_cur,
   input  logic [15:0]               dst_port_cur,
   input  logic [15:0]               hdr_sum_cur,
   output udp_rx_pkg::merge_res_type merge_res
);

   localparam int CW = udp_rx_pkg::CNT_W;

   logic [63:0]                            masked;
   logic [CW-1:0]                          hdr_cnt;
   logic [CW-1:0]                          pay_cnt;
   logic [CW-1:0]                          kept_cnt;
   logic [udp_rx_pkg::BEAT_SUM_W-1:0]      beat_sum;
   logic [15:0]                            src_port;
   logic [15:0]                            dst_port;
   logic [15:0]                            hdr_sum;

   always_comb begin
      masked   = '0;
      hdr_cnt  = '0;
      pay_cnt  = '0;
      kept_cnt = '0;
      beat_sum = '0;
      src_port = src_port_cur;
      dst_port = dst_port_cur;
      hdr_sum  = hdr_sum_cur;
      for (int k = 0; k < BUS_BYTES; k++) begin
         beat_sum = beat_sum + udp_rx_pkg::BEAT_SUM_W'(lane_res[k].term);
         kept_cnt = kept_cnt + CW'(lane_res[k].kept);
         pay_cnt  = pay_cnt + CW'(lane_res[k].payload);
         if (lane_res[k].payload) begin
            masked[8*k +: 8] = lane_res[k].data;
         end
         if (lane_res[k].kept && !lane_res[k].payload) begin
            hdr_cnt = hdr_cnt + CW'(1);
            case (lane_res[k].hdr_pos)
               udp_rx_pkg::HDR_SRC_HI: src_port[15:8] = lane_res[k].data;
               udp_rx_pkg::HDR_SRC_LO: src_port[7:0]  = lane_res[k].data;
               udp_rx_pkg::HDR_DST_HI: dst_port[15:8] = lane_res[k].data;
               udp_rx_pkg::HDR_DST_LO: dst_port[7:0]  = lane_res[k].data;
               udp_rx_pkg::HDR_CKS_HI: hdr_sum[15:8]  = lane_res[k].data;
               udp_rx_pkg::HDR_CKS_LO: hdr_sum[7:0]   = lane_res[k].data;
               default: ;
            endcase
         end
      end

      // header lanes always precede payload lanes, so drop them with a shift
      merge_res.payload_data  = masked >> {hdr_cnt, 3'b000};
      merge_res.payload_bytes = pay_cnt;
      merge_res.kept_cnt      = kept_cnt;
      merge_res.beat_sum      = beat_sum;
      merge_res.src_port      = src_port;
      merge_res.dst_port      = dst_port;
      merge_res.hdr_sum       = hdr_sum;
   end

endmodule

// File: src/udp_datagram_receiver_top.sv
// UDP receive path: one request carries a bus beat of up to BUS_BYTES datagram bytes, lane 0
// first, and yields one response carrying that beat's payload bytes packed from bit 0; the
// response to the beat marked last also carries the ports, the payload byte total and the
// checksum verdict over pseudo-header, header and payload. Addresses and length are taken on
// the first beat after reset or after a last beat. A request is taken every clock unless
// req_stall is high: each lane handles one byte, so the per-beat work is one lane pass plus
// a merge, and the running sum is carried one stage later. Beats are registered in the first
// stage, responses in the second; rsp_stall fills the two-deep pipe before req_stall rises.
module udp_datagram_receiver_top #(
   parameter int BUS_BYTES = udp_rx_pkg::BUS_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  udp_rx_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output udp_rx_pkg::rsp_type rsp_data
);

   localparam int CW = udp_rx_pkg::CNT_W;
   localparam int SW = udp_rx_pkg::BEAT_SUM_W;
   localparam int TW = udp_rx_pkg::TOTAL_W;

   // per-datagram state
   logic [15:0] byte_offset_ff,   byte_offset_in;
   logic        in_dgram_ff,      in_dgram_in;
   logic [15:0] src_port_ff,      src_port_in;
   logic [15:0] dst_port_ff,      dst_port_in;
   logic [15:0] hdr_sum_ff,       hdr_sum_in;
   logic [15:0] payload_count_ff, payload_count_in;

   // first stage
   logic          s1_valid_ff,    s1_valid_in;
   logic [63:0]   s1_pdata_ff;
   logic [CW-1:0] s1_pbytes_ff;
   logic          s1_last_ff;
   logic [15:0]   s1_src_port_ff;
   logic [15:0]   s1_dst_port_ff;
   logic          s1_hdr_zero_ff;
   logic [15:0]   s1_total_ff;
   logic [SW-1:0] s1_beat_sum_ff;
   logic [SW-1:0] s1_pseudo_ff;

   // second stage: running sum and response register
   logic [15:0]         acc_ff, acc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   udp_rx_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic                      req_take;
   logic                      s1_move;
   logic                      out_free;
   logic [CW-1:0]             beat_cnt;
   logic [SW-1:0]             pseudo_sum;
   logic [TW-1:0]             total;
   logic [15:0]               folded;
   udp_rx_pkg::lane_res_type  lane_res [BUS_BYTES];
   udp_rx_pkg::merge_res_type merge_res;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign beat_cnt = (req_data.beat_bytes > CW'(BUS_BYTES)) ? CW'(BUS_BYTES)
                                                            : req_data.beat_bytes;

   for (genvar k = 0; k < BUS_BYTES; k++) begin : g_lane
      udp_rx_lane #(
         .LANE(k)
      ) u_lane (
         .byte_offset (byte_offset_ff),
         .beat_cnt    (beat_cnt),
         .lane_data   (req_data.beat_data[8*k +: 8]),
         .lane_res    (lane_res[k])
      );
   end

   udp_rx_merge #(
      .BUS_BYTES(BUS_BYTES)
   ) u_merge (
      .lane_res     (lane_res),
      .src_port_cur (src_port_ff),
      .dst_port_cur (dst_port_ff),
      .hdr_sum_cur  (hdr_sum_ff),
      .merge_res    (merge_res)
   );

   always_comb begin
      pseudo_sum = '0;
      if (!in_dgram_ff) begin
         pseudo_sum = SW'(req_data.udp_len) + SW'(udp_rx_pkg::PROTO_UDP)
                    + SW'(req_data.src_addr[31:16]) + SW'(req_data.src_addr[15:0])
                    + SW'(req_data.dst_addr[31:16]) + SW'(req_data.dst_addr[15:0]);
      end
   end

   always_comb begin
      byte_offset_in   = byte_offset_ff;
      in_dgram_in      = in_dgram_ff;
      src_port_in      = src_port_ff;
      dst_port_in      = dst_port_ff;
      hdr_sum_in       = hdr_sum_ff;
      payload_count_in = payload_count_ff;
      if (req_take) begin
         if (req_data.beat_last) begin
            byte_offset_in   = '0;
            in_dgram_in      = 1'b0;
            src_port_in      = '0;
            dst_port_in      = '0;
            hdr_sum_in       = '0;
            payload_count_in = '0;
         end else begin
            // kept lanes never carry the offset past saturation
            byte_offset_in   = byte_offset_ff + 16'(merge_res.kept_cnt);
            in_dgram_in      = 1'b1;
            src_port_in      = merge_res.src_port;
            dst_port_in      = merge_res.dst_port;
            hdr_sum_in       = merge_res.hdr_sum;
            payload_count_in = payload_count_ff + 16'(merge_res.payload_bytes);
         end
      end
   end

   assign s1_valid_in = req_take || (s1_valid_ff && !out_free);

   always_comb begin
      total  = TW'(acc_ff) + TW'(s1_beat_sum_ff) + TW'(s1_pseudo_ff);
      folded = udp_rx_pkg::oc_fold(total);

      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (s1_move) begin
         acc_in                    = s1_last_ff ? 16'h0000 : folded;
         rsp_valid_in              = 1'b1;
         rsp_data_in.payload_data  = s1_pdata_ff;
         rsp_data_in.payload_bytes = s1_pbytes_ff;
         rsp_data_in.done_res      = s1_last_ff;
         rsp_data_in.checksum_ok   = s1_last_ff
                                     && (s1_hdr_zero_ff || folded == udp_rx_pkg::CKS_GOOD);
         rsp_data_in.src_port      = s1_last_ff ? s1_src_port_ff : 16'h0000;
         rsp_data_in.dst_port      = s1_last_ff ? s1_dst_port_ff : 16'h0000;
         rsp_data_in.payload_total = s1_last_ff ? s1_total_ff : 16'h0000;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_offset_ff   <= '0;
         in_dgram_ff      <= 1'b0;
         src_port_ff      <= '0;
         dst_port_ff      <= '0;
         hdr_sum_ff       <= '0;
         payload_count_ff <= '0;
         s1_valid_ff      <= 1'b0;
         acc_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         byte_offset_ff   <= byte_offset_in;
         in_dgram_ff      <= in_dgram_in;
         src_port_ff      <= src_port_in;
         dst_port_ff      <= dst_port_in;
         hdr_sum_ff       <= hdr_sum_in;
         payload_count_ff <= payload_count_in;
         s1_valid_ff      <= s1_valid_in;
         acc_ff           <= acc_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_pdata_ff    <= merge_res.payload_data;
         s1_pbytes_ff   <= merge_res.payload_bytes;
         s1_last_ff     <= req_data.beat_last;
         s1_src_port_ff <= merge_res.src_port;
         s1_dst_port_ff <= merge_res.dst_port;
         s1_hdr_zero_ff <= (merge_res.hdr_sum == 16'h0000);
         s1_total_ff    <= payload_count_ff + 16'(merge_res.payload_bytes);
         s1_beat_sum_ff <= merge_res.beat_sum;
         s1_pseudo_ff   <= pseudo_sum;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
